/* design/aeg_pkg.sv */
// package for the adsr envelope generator: widths, reset values, register
// indexes, segment codes and sequencer state types
// no dependencies
`default_nettype none

package aeg_pkg;

   // default field widths
   localparam int AEG_LEN_BITS   = 20;
   localparam int AEG_LEVEL_BITS = 16;

   // unit level in q2.14 and the bits it needs
   localparam int AEG_UNIT_LEVEL = 16384;
   localparam int AEG_UNIT_BITS  = 15;

   // register reset values, cut to the register width where they are used
   localparam int AEG_ATTACK_RESET  = 480;
   localparam int AEG_PEAK_RESET    = 24576;
   localparam int AEG_DECAY_RESET   = 480;
   localparam int AEG_SUSTAIN_RESET = 4800;
   localparam int AEG_RELEASE_RESET = 4800;

   // register indexes
   localparam int AEG_CSR_INDEX_BITS = 3;
   localparam logic [AEG_CSR_INDEX_BITS-1:0] CSR_ATTACK_LEN  = 3'd0;
   localparam logic [AEG_CSR_INDEX_BITS-1:0] CSR_PEAK_LEVEL  = 3'd1;
   localparam logic [AEG_CSR_INDEX_BITS-1:0] CSR_DECAY_LEN   = 3'd2;
   localparam logic [AEG_CSR_INDEX_BITS-1:0] CSR_SUSTAIN_LEN = 3'd3;
   localparam logic [AEG_CSR_INDEX_BITS-1:0] CSR_RELEASE_LEN = 3'd4;

   // envelope segments
   typedef enum logic [1:0] {
      SEG_ATTACK  = 2'd0,
      SEG_DECAY   = 2'd1,
      SEG_SUSTAIN = 2'd2,
      SEG_RELEASE = 2'd3
   } seg_type;

   // main sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_END_D,
      ST_END_S,
      ST_TOTAL,
      ST_LOCATE,
      ST_LAST,
      ST_CMP_A,
      ST_CMP_D,
      ST_CMP_S,
      ST_MULDIV,
      ST_DONE
   } seq_state_type;

   // serial multiply / divide unit
   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

endpackage

`default_nettype wire

/* design/adsr_envelope_generator.sv */
// linear adsr envelope generator, top level
// uses aeg_pkg, aeg_csr and aeg_muldiv
//
// Each request on the req_ channel (one restart bit) yields one envelope
// sample on the rsp_ channel: level (q2.14), segment and a last flag, or no
// sample at all when the four segment lengths add up to zero. A request with
// restart set starts the envelope over at position zero.
// Requests are handled one at a time. For an attack, decay or release sample
// the serial multiply and then the serial divide, one bit a cycle each, give
// the level; a sustain sample needs neither.
// The next request is taken the cycle after the result is loaded.
// A result waits in the output register while rsp_ready is low; the next
// request is still accepted and worked on, and it stalls only when its own
// result finds the output register full.
// Registers are written through csr_we/csr_index/csr_wdata; the user must write
// them only while idle; the block does not enforce it. Synchronous reset restores
// the register defaults, sets the position to zero and empties the output register.
`default_nettype none

module adsr_envelope_generator #(
   parameter int  LEN_BITS   = aeg_pkg::AEG_LEN_BITS,
   parameter int  LEVEL_BITS = aeg_pkg::AEG_LEVEL_BITS,
   localparam int DATA_BITS  = (LEN_BITS > LEVEL_BITS) ? LEN_BITS : LEVEL_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_restart,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic      [LEVEL_BITS-1:0]                   rsp_level,
   output logic      [1:0]                              rsp_segment,
   output logic                                         rsp_last,
   input  wire logic                                    csr_we,
   input  wire logic [aeg_pkg::AEG_CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [DATA_BITS-1:0]                    csr_wdata
);
   import aeg_pkg::*;

   localparam int POS_BITS   = LEN_BITS + 2;
   localparam int MUL_BITS   = (LEVEL_BITS > AEG_UNIT_BITS) ? LEVEL_BITS : AEG_UNIT_BITS;
   localparam int LVL_WIDE   = MUL_BITS + 1;

   logic [LEN_BITS-1:0]   attack_len, decay_len, sustain_len, release_len;
   logic [LEVEL_BITS-1:0] peak_level;

   seq_state_type         state_ff, state_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   end_d_ff, end_d_in;
   logic [POS_BITS-1:0]   end_s_ff, end_s_in;
   logic [POS_BITS-1:0]   total_ff, total_in;
   logic [POS_BITS-1:0]   k_ff, k_in;
   logic                  last_ff, last_in;
   seg_type               seg_ff, seg_in;
   logic                  dec_up_ff, dec_up_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   seg_type               rsp_segment_ff, rsp_segment_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  md_start, md_done;
   logic [LEN_BITS-1:0]   md_a, md_div;
   logic [MUL_BITS-1:0]   md_b, md_quo;

   logic [POS_BITS-1:0]   k_next;
   logic [LVL_WIDE-1:0]   lvl_wide;
   logic [LVL_WIDE-1:0]   peak_wide, quo_wide, unit_wide;

   aeg_csr #(
      .LEN_BITS   (LEN_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .attack_len  (attack_len),
      .peak_level  (peak_level),
      .decay_len   (decay_len),
      .sustain_len (sustain_len),
      .release_len (release_len)
   );

   aeg_muldiv #(
      .LEN_BITS (LEN_BITS),
      .MUL_BITS (MUL_BITS)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .mul_a    (md_a),
      .mul_b    (md_b),
      .divisor  (md_div),
      .done     (md_done),
      .quotient (md_quo)
   );

   assign k_next    = k_ff + 1'b1;
   assign peak_wide = LVL_WIDE'(peak_level);
   assign quo_wide  = LVL_WIDE'(md_quo);
   assign unit_wide = LVL_WIDE'(AEG_UNIT_LEVEL);

   // level from segment and quotient
   always_comb begin
      unique case (seg_ff)
         SEG_ATTACK:  lvl_wide = quo_wide;
         SEG_DECAY:   lvl_wide = dec_up_ff ? (peak_wide + quo_wide) : (peak_wide - quo_wide);
         SEG_SUSTAIN: lvl_wide = unit_wide;
         SEG_RELEASE: lvl_wide = unit_wide - quo_wide;
         default:     lvl_wide = unit_wide;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      end_d_ff       <= end_d_in;
      end_s_ff       <= end_s_in;
      total_ff       <= total_in;
      k_ff           <= k_in;
      last_ff        <= last_in;
      seg_ff         <= seg_in;
      dec_up_ff      <= dec_up_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_segment_ff <= rsp_segment_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // sequencer: segment ends, position wrap, classify, serial multiply and divide, result
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      end_d_in       = end_d_ff;
      end_s_in       = end_s_ff;
      total_in       = total_ff;
      k_in           = k_ff;
      last_in        = last_ff;
      seg_in         = seg_ff;
      dec_up_in      = dec_up_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_segment_in = rsp_segment_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      req_ready      = 1'b0;
      md_start       = 1'b0;
      md_a           = '0;
      md_b           = '0;
      md_div         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart) begin
                  pos_in = '0;
               end
               state_in = ST_END_D;
            end
         end
         ST_END_D: begin
            end_d_in = POS_BITS'(attack_len) + POS_BITS'(decay_len);
            state_in = ST_END_S;
         end
         ST_END_S: begin
            end_s_in = end_d_ff + POS_BITS'(sustain_len);
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            total_in = end_s_ff + POS_BITS'(release_len);
            state_in = ST_LOCATE;
         end
         ST_LOCATE: begin
            // empty envelope gives no sample
            if (total_ff == '0) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end else begin
               k_in     = (pos_ff >= total_ff) ? '0 : pos_ff;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            last_in  = (k_next == total_ff);
            pos_in   = (k_next == total_ff) ? '0 : k_next;
            state_in = ST_CMP_A;
         end
         ST_CMP_A: begin
            if (k_ff < POS_BITS'(attack_len)) begin
               seg_in   = SEG_ATTACK;
               md_start = 1'b1;
               md_a     = k_ff[LEN_BITS-1:0];
               md_b     = MUL_BITS'(peak_level);
               md_div   = attack_len;
               state_in = ST_MULDIV;
            end else begin
               state_in = ST_CMP_D;
            end
         end
         ST_CMP_D: begin
            if (k_ff < end_d_ff) begin
               seg_in    = SEG_DECAY;
               dec_up_in = (peak_wide < unit_wide);
               md_start  = 1'b1;
               md_a      = LEN_BITS'(k_ff - POS_BITS'(attack_len));
               md_b      = (peak_wide < unit_wide) ? MUL_BITS'(unit_wide - peak_wide)
                                                   : MUL_BITS'(peak_wide - unit_wide);
               md_div    = decay_len;
               state_in  = ST_MULDIV;
            end else begin
               state_in = ST_CMP_S;
            end
         end
         ST_CMP_S: begin
            if (k_ff < end_s_ff) begin
               seg_in   = SEG_SUSTAIN;
               state_in = ST_DONE;
            end else begin
               seg_in   = SEG_RELEASE;
               md_start = 1'b1;
               md_a     = LEN_BITS'(k_ff - end_s_ff);
               md_b     = MUL_BITS'(unit_wide);
               md_div   = release_len;
               state_in = ST_MULDIV;
            end
         end
         ST_MULDIV: begin
            if (md_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_level_in   = lvl_wide[LEVEL_BITS-1:0];
               rsp_segment_in = seg_ff;
               rsp_last_in    = last_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_level   = rsp_level_ff;
   assign rsp_segment = rsp_segment_ff;
   assign rsp_last    = rsp_last_ff;

   // wrapped position always lies inside the envelope
   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP_A) |-> (k_ff < total_ff))
      else $error("sample position outside the envelope");

   // the divider is never started for an empty envelope
   a_no_div_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULDIV) |-> (total_ff != '0))
      else $error("divide running on an empty envelope");

   // last sample leaves the position at zero
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && last_ff) |-> (pos_ff == '0))
      else $error("position not wrapped after last sample");

   // attack ramp never overshoots the peak
   a_attack_peak: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && seg_ff == SEG_ATTACK) |-> (quo_wide <= peak_wide))
      else $error("attack level above peak");

endmodule

`default_nettype wire

/* design/aeg_csr.sv */
// configuration registers of the adsr envelope generator
// depends on aeg_pkg
`default_nettype none

module aeg_csr #(
   parameter int  LEN_BITS   = aeg_pkg::AEG_LEN_BITS,
   parameter int  LEVEL_BITS = aeg_pkg::AEG_LEVEL_BITS,
   localparam int DATA_BITS  = (LEN_BITS > LEVEL_BITS) ? LEN_BITS : LEVEL_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_we,
   input  wire logic [aeg_pkg::AEG_CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [DATA_BITS-1:0]                    csr_wdata,
   output logic      [LEN_BITS-1:0]                     attack_len,
   output logic      [LEVEL_BITS-1:0]                   peak_level,
   output logic      [LEN_BITS-1:0]                     decay_len,
   output logic      [LEN_BITS-1:0]                     sustain_len,
   output logic      [LEN_BITS-1:0]                     release_len
);
   import aeg_pkg::*;

   logic [LEN_BITS-1:0]   attack_ff, decay_ff, sustain_ff, release_ff;
   logic [LEVEL_BITS-1:0] peak_ff;

   // register writes, out-of-range indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= LEN_BITS'(AEG_ATTACK_RESET);
         peak_ff    <= LEVEL_BITS'(AEG_PEAK_RESET);
         decay_ff   <= LEN_BITS'(AEG_DECAY_RESET);
         sustain_ff <= LEN_BITS'(AEG_SUSTAIN_RESET);
         release_ff <= LEN_BITS'(AEG_RELEASE_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATTACK_LEN:  attack_ff  <= csr_wdata[LEN_BITS-1:0];
            CSR_PEAK_LEVEL:  peak_ff    <= csr_wdata[LEVEL_BITS-1:0];
            CSR_DECAY_LEN:   decay_ff   <= csr_wdata[LEN_BITS-1:0];
            CSR_SUSTAIN_LEN: sustain_ff <= csr_wdata[LEN_BITS-1:0];
            CSR_RELEASE_LEN: release_ff <= csr_wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign attack_len  = attack_ff;
   assign peak_level  = peak_ff;
   assign decay_len   = decay_ff;
   assign sustain_len = sustain_ff;
   assign release_len = release_ff;

endmodule

`default_nettype wire

/* design/aeg_muldiv.sv */
// bit-serial multiply then restoring divide: quotient = (a * b) / divisor
// one product bit then one quotient bit per cycle, sharing one register
// depends on aeg_pkg
`default_nettype none

module aeg_muldiv #(
   parameter int LEN_BITS = aeg_pkg::AEG_LEN_BITS,
   parameter int MUL_BITS = aeg_pkg::AEG_UNIT_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [LEN_BITS-1:0] mul_a,
   input  wire logic [MUL_BITS-1:0] mul_b,
   input  wire logic [LEN_BITS-1:0] divisor,
   output logic                     done,
   output logic      [MUL_BITS-1:0] quotient
);
   import aeg_pkg::*;

   localparam int PROD_BITS = LEN_BITS + MUL_BITS;
   localparam int MAX_STEPS = (LEN_BITS > MUL_BITS) ? LEN_BITS : MUL_BITS;
   localparam int CNT_BITS  = $clog2(MAX_STEPS);

   md_state_type          state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [MUL_BITS-1:0]   mcand_ff, mcand_in;
   logic [LEN_BITS-1:0]   div_ff, div_in;

   logic [MUL_BITS:0]     mul_sum;
   logic [LEN_BITS:0]     trial;
   logic [LEN_BITS:0]     trial_diff;
   logic                  trial_ge;

   // multiply step: add multiplicand into the upper part when the low bit is set
   assign mul_sum = {1'b0, prod_ff[PROD_BITS-1:LEN_BITS]}
                  + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   // divide step: shift the next dividend bit into the partial remainder
   assign trial      = {prod_ff[PROD_BITS-1:MUL_BITS], prod_ff[MUL_BITS-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign trial_ge   = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
      div_ff   <= div_in;
   end

   // step sequencing
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      div_in   = div_ff;
      done     = 1'b0;
      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               prod_in  = {{MUL_BITS{1'b0}}, mul_a};
               mcand_in = mul_b;
               div_in   = divisor;
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            prod_in = {mul_sum, prod_ff[LEN_BITS-1:1]};
            if (cnt_ff == CNT_BITS'(LEN_BITS - 1)) begin
               cnt_in   = '0;
               state_in = MD_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         MD_DIV: begin
            prod_in = {(trial_ge ? trial_diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0]),
                       prod_ff[MUL_BITS-2:0], trial_ge};
            if (cnt_ff == CNT_BITS'(MUL_BITS - 1)) begin
               cnt_in   = '0;
               done     = 1'b1;
               state_in = MD_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   assign quotient = prod_ff[MUL_BITS-1:0];

endmodule

`default_nettype wire
